// ===== rtl/vprc_pkg.sv =====
// Package for the valve PWM ramp controller: field widths, register
// indexes, valve state codes and register reset values.
// No dependencies.
package vprc_pkg;

    localparam int DUTY_W  = 15;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;
    localparam int STATE_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED  = 2'd0,
        ST_OPENED  = 2'd1,
        ST_PENDING = 2'd2
    } valve_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_MIN   = 8'd0,
        REG_DUTY_MAX   = 8'd1,
        REG_DUTY_STEP  = 8'd2,
        REG_STEP_DELAY = 8'd3
    } cfg_reg_t;

    localparam logic [DUTY_W-1:0]  DUTY_MIN_RST   = 15'd0;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST   = 15'd1000;
    localparam logic [DUTY_W-1:0]  DUTY_STEP_RST  = 15'd10;
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd10;

endpackage

// ===== rtl/vprc_if.sv =====
// Valid/ready channel interfaces of the valve PWM ramp controller:
// request channel in, state/duty channel out.
// Depends on vprc_pkg.
interface vprc_req_if;
    import vprc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  requested_state;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output requested_state, output now_ms, input ready);
    modport sink   (input valid, input requested_state, input now_ms, output ready);
endinterface

interface vprc_res_if;
    import vprc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  valve_state;
    logic [DUTY_W-1:0]   duty;

    modport source (output valid, output valve_state, output duty, input ready);
    modport sink   (input valid, input valve_state, input duty, output ready);
endinterface

// ===== rtl/valve_pwm_ramp_controller.sv =====
// Valve PWM ramp controller top level: request register, state update
// with duty slew limiting, result register.
// Depends on vprc_pkg and the channel interfaces in vprc_if.sv.

// Each request transfer carries a wanted valve state and the current
// millisecond time, and produces exactly one result transfer with the
// valve state and PWM duty after that request. A close request ramps the
// duty down by duty_step, an open request ramps it up, at most one step per
// step_delay_ms (wrapping 32-bit time difference), clamped to
// [duty_min, duty_max]; until the end point is reached the state reads
// pending. Throughput is one request per clock while the result side does
// not stall: a request is registered, then the update logic (one 32-bit
// subtract and compare, one 17-bit add and clamp) writes the state
// registers and the result register together once the result register
// is empty or being read. Either register may hold while the result side
// stalls; a new request is taken whenever the request register is empty
// or moving on. Configuration writes are meant for idle periods only and
// never touch the live duty, which follows new limits at the next ramp
// step. Writes to indexes above three are ignored.
module valve_pwm_ramp_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vprc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vprc_pkg::CFG_DATA_W-1:0] cfg_data,
    vprc_req_if.sink                      req,
    vprc_res_if.source                    res
);
    import vprc_pkg::*;

    // configuration
    logic [DUTY_W-1:0]  duty_min_reg;
    logic [DUTY_W-1:0]  duty_max_reg;
    logic [DUTY_W-1:0]  duty_step_reg;
    logic [DELAY_W-1:0] step_delay_reg;

    // request register
    logic               in_valid_reg;
    logic [STATE_W-1:0] in_state_reg;
    logic [TIME_W-1:0]  in_now_reg;

    // controller state
    valve_state_t       state_reg, state_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [TIME_W-1:0]  last_change_reg, last_change_next;

    // result register
    logic               out_valid_reg;
    valve_state_t       out_state_reg;
    logic [DUTY_W-1:0]  out_duty_reg;

    logic advance;
    logic delay_passed;
    logic signed [DUTY_W+1:0] target;
    logic signed [DUTY_W+1:0] clamped;
    logic signed [DUTY_W+1:0] min_s;
    logic signed [DUTY_W+1:0] max_s;
    logic [TIME_W-1:0] elapsed;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    assign res.valid       = out_valid_reg;
    assign res.valve_state = out_state_reg;
    assign res.duty        = out_duty_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg   <= DUTY_MIN_RST;
            duty_max_reg   <= DUTY_MAX_RST;
            duty_step_reg  <= DUTY_STEP_RST;
            step_delay_reg <= STEP_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DUTY_MIN:   duty_min_reg   <= cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX:   duty_max_reg   <= cfg_data[DUTY_W-1:0];
                REG_DUTY_STEP:  duty_step_reg  <= cfg_data[DUTY_W-1:0];
                REG_STEP_DELAY: step_delay_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // ramp step: exact signed sum or difference, raise to min, then cap at max
    assign elapsed      = in_now_reg - last_change_reg;
    assign delay_passed = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, step_delay_reg};
    assign min_s        = signed'({2'b00, duty_min_reg});
    assign max_s        = signed'({2'b00, duty_max_reg});

    always_comb
    begin
        if (in_state_reg == ST_CLOSED)
            target = signed'({2'b00, duty_reg}) - signed'({2'b00, duty_step_reg});
        else
            target = signed'({2'b00, duty_reg}) + signed'({2'b00, duty_step_reg});
        clamped = target;
        if (clamped < min_s)
            clamped = min_s;
        if (clamped > max_s)
            clamped = max_s;
    end

    always_comb
    begin
        state_next       = state_reg;
        duty_next        = duty_reg;
        last_change_next = last_change_reg;
        if (in_state_reg != state_reg)
        begin
            state_next = ST_PENDING;
            case (in_state_reg)
                ST_CLOSED:
                begin
                    if (duty_reg <= duty_min_reg)
                        state_next = ST_CLOSED;
                    else if (delay_passed)
                    begin
                        duty_next        = clamped[DUTY_W-1:0];
                        last_change_next = in_now_reg;
                    end
                end
                ST_OPENED:
                begin
                    if (duty_reg == duty_max_reg)
                        state_next = ST_OPENED;
                    else if (delay_passed)
                    begin
                        duty_next        = clamped[DUTY_W-1:0];
                        last_change_next = in_now_reg;
                    end
                end
                default: ;  // pending and the unused code just go pending
            endcase
        end
    end

    // request register, state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= ST_CLOSED;
            duty_reg        <= DUTY_MIN_RST;
            last_change_reg <= '0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
            begin
                state_reg       <= state_next;
                duty_reg        <= duty_next;
                last_change_reg <= last_change_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_state_reg <= req.requested_state;
            in_now_reg   <= req.now_ms;
        end
        if (advance)
        begin
            out_state_reg <= state_next;
            out_duty_reg  <= duty_next;
        end
    end

endmodule

// ===== verif/valve_pwm_ramp_controller_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for valve_pwm_ramp_controller: directed and random
// request transfers checked against a cycle-free duty ramp predictor.
// Depends on vprc_pkg, the channel interfaces in vprc_if.sv and the RTL top.
module valve_pwm_ramp_controller_test;
    import vprc_pkg::*;

    localparam int          CYCLE_LIMIT = 200000; // far beyond the slowest legal run
    localparam int          DRAIN_LIMIT = 2000;   // covers the long hold-off easily
    localparam int          SETTLE      = 6;      // drains the request and result registers, plus margin
    localparam int          LONG_HOLD   = 120;    // result side blocked, pipe must fill
    localparam int          MAX_GAP     = 13;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 50;
    localparam logic [1:0]  REQ_UNDEFINED = 2'd3;         // request code with no state
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200; // write must be ignored

    // Expected reading of one result transfer.
    typedef struct packed {
        valve_state_t       vstate;
        logic [DUTY_W-1:0]  duty;
    } valve_reading_t;

    // Tracks valve state, duty and limits the way the block should, and
    // queues the reading each accepted request must produce.
    class valve_duty_tracker;
        logic [DUTY_W-1:0]  duty_min;
        logic [DUTY_W-1:0]  duty_max;
        logic [DUTY_W-1:0]  duty_step;
        logic [DELAY_W-1:0] delay_ms;
        valve_state_t       cur_state;
        logic [DUTY_W-1:0]  cur_duty;
        logic [TIME_W-1:0]  last_change;
        valve_reading_t     due_readings[$];
        int                 fails;

        function new();
            duty_min    = DUTY_MIN_RST;
            duty_max    = DUTY_MAX_RST;
            duty_step   = DUTY_STEP_RST;
            delay_ms    = STEP_DELAY_RST;
            cur_state   = ST_CLOSED;
            cur_duty    = DUTY_MIN_RST;
            last_change = '0;
            fails       = 0;
        endfunction

        function void report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            fails++;
        endfunction

        function int due_count();
            return due_readings.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DUTY_MIN:   duty_min  = val[DUTY_W-1:0];
                REG_DUTY_MAX:   duty_max  = val[DUTY_W-1:0];
                REG_DUTY_STEP:  duty_step = val[DUTY_W-1:0];
                REG_STEP_DELAY: delay_ms  = val;
                default: ;
            endcase
        endfunction

        // Exact signed target, raised to the floor first, then cut to the ceiling.
        function void ramp_to(int target, logic [TIME_W-1:0] now);
            int t;
            t = target;
            if (t < int'(duty_min)) t = int'(duty_min);
            if (t > int'(duty_max)) t = int'(duty_max);
            cur_duty    = t[DUTY_W-1:0];
            last_change = now;
        endfunction

        function void take_request(logic [STATE_W-1:0] req, logic [TIME_W-1:0] now);
            logic              done;
            logic [TIME_W-1:0] elapsed;
            valve_reading_t    rd;
            elapsed = now - last_change;
            done    = 1'b0;
            if (req != cur_state) begin
                if (req == ST_CLOSED) begin
                    if (cur_duty <= duty_min)
                        done = 1'b1;
                    else if (elapsed >= {16'd0, delay_ms})
                        ramp_to(int'(cur_duty) - int'(duty_step), now);
                end else if (req == ST_OPENED) begin
                    if (cur_duty == duty_max)
                        done = 1'b1;
                    else if (elapsed >= {16'd0, delay_ms})
                        ramp_to(int'(cur_duty) + int'(duty_step), now);
                end
                cur_state = done ? valve_state_t'(req) : ST_PENDING;
            end
            rd.vstate = cur_state;
            rd.duty   = cur_duty;
            due_readings.push_back(rd);
        endfunction

        function void match_result(logic [STATE_W-1:0] st, logic [DUTY_W-1:0] duty);
            valve_reading_t rd;
            if (due_readings.size() == 0) begin
                report($sformatf("unexpected result state=%0d duty=%0d", st, duty));
                return;
            end
            rd = due_readings.pop_front();
            if (st !== rd.vstate)
                report($sformatf("valve_state %0d, expected %0d", st, rd.vstate));
            if (duty !== rd.duty)
                report($sformatf("duty %0d, expected %0d", duty, rd.duty));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vprc_req_if req_ch();
    vprc_res_if res_ch();

    valve_duty_tracker board = new;

    int cycle_count = 0;
    int rx_wait     = 0;
    int rx_hold     = 0;
    int rx_seen     = 0;
    bit tx_calm     = 1'b0;  // sender offers back to back
    bit rx_calm     = 1'b0;  // receiver adds no random gaps (the long holds still apply)

    valve_pwm_ramp_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Result monitor: values seen at the edge are the pre-edge ones, so the
    // check does not depend on process order.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.match_result(res_ch.valve_state, res_ch.duty);
    end

    // Result side back-pressure. A gap is drawn after every transfer but two;
    // after those two the receiver blocks instead, for a long hold, so that both
    // pipeline registers fill and the request side must stall.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            rx_seen++;
            if (rx_seen == 150 || rx_seen == 330)
                rx_hold = LONG_HOLD;
            else
                rx_wait = draw_gap(rx_calm);
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            res_ch.ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // One request transfer. Entered and left on a rising edge; valid is left
    // high so that a zero gap carries straight on to the next item.
    task automatic send_request(input logic [STATE_W-1:0] rs, input logic [TIME_W-1:0] t);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.requested_state <= rs;
        req_ch.now_ms          <= t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.take_request(rs, t);
    endtask

    // Lower valid and wait until every queued reading has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (board.due_count() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (board.due_count() != 0)
        begin
            board.report($sformatf("%0d results never arrived", board.due_count()));
            board.due_readings.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // All four limits plus a write to a dead index; only called while idle.
    task automatic set_limits(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] dl);
        put_reg(REG_DUTY_MIN, lo);
        put_reg(REG_DUTY_MAX, hi);
        put_reg(REG_DUTY_STEP, st);
        put_reg(REG_STEP_DELAY, dl);
        put_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic random_limits();
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] st;
        logic [CFG_DATA_W-1:0] dl;
        case ($urandom_range(0, 2))
            0:       lo = '0;
            1:       lo = 16'($urandom_range(0, 500));
            default: lo = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0:       hi = 16'h7FFF;
            1:       hi = {1'b0, lo[DUTY_W-1:0]} + 16'($urandom_range(0, 3000));
            default: hi = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       st = '0;
            1:       st = 16'd1;
            2:       st = 16'($urandom_range(1, 300));
            3:       st = 16'h7FFF;
            default: st = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       dl = '0;
            1:       dl = 16'($urandom_range(1, 20));
            2:       dl = 16'hFFFF;
            default: dl = 16'($urandom);
        endcase
        set_limits(lo, hi, st, dl);
    endtask

    // Time advance between requests: mostly around the step delay so ramps
    // make progress, with the odd large jump that wraps the 32-bit clock.
    function automatic logic [TIME_W-1:0] time_gap();
        logic [TIME_W-1:0] d;
        d = {16'd0, board.delay_ms};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return (d == 0) ? '0 : d - 1;
            2, 3:    return d;
            4:       return d + $urandom_range(0, 3);
            5, 6:    return $urandom_range(0, 2 * d + 1);
            default: return $urandom;
        endcase
    endfunction

    // Mostly runs of one open or close request with random timing; the
    // rest pending, the undefined code and lone requests.
    task automatic run_phase(input int count);
        logic [TIME_W-1:0]  t;
        logic [STATE_W-1:0] rs;
        valve_state_t       dir;
        int                 n;
        int                 len;
        n = 0;
        t = $urandom;
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                dir = $urandom_range(0, 1) ? ST_OPENED : ST_CLOSED;
                len = $urandom_range(2, 12);
                for (int k = 0; k < len && n < count; k++)
                begin
                    t += time_gap();
                    send_request(dir, t);
                    n++;
                end
            end
            else
            begin
                rs = STATE_W'($urandom_range(0, 3));
                t += time_gap();
                send_request(rs, t);
                n++;
            end
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] t;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.requested_state = '0;
        req_ch.now_ms          = '0;
        res_ch.ready           = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset limits: floor 0, ceiling 1000, step 10, delay 10
        send_request(ST_CLOSED, 32'd0);       // already closed: no change
        send_request(ST_PENDING, 32'd3);      // pending request
        send_request(REQ_UNDEFINED, 32'd4);   // undefined code behaves as pending
        send_request(ST_CLOSED, 32'd5);       // duty at floor: closes at once
        send_request(ST_OPENED, 32'd9);       // one ms short of the delay
        send_request(ST_OPENED, 32'd10);      // delay exactly met
        send_request(ST_OPENED, 32'd19);
        send_request(ST_OPENED, 32'hFFFF_FFFF);
        send_request(ST_OPENED, 32'd8);       // elapsed time across the wrap: 9
        send_request(ST_OPENED, 32'd9);       // and now 10
        send_request(ST_CLOSED, 32'd9);       // direction change inside delay
        send_request(ST_CLOSED, 32'd100);
        drain_results();

        // step lands beyond the ceiling and is clamped, then opened
        set_limits(16'd0, 16'd25, 16'd10, 16'd0);
        send_request(ST_OPENED, 32'd200);
        send_request(ST_OPENED, 32'd200);
        drain_results();

        // ceiling lowered below the live duty: the open step pulls it down
        set_limits(16'd0, 16'd15, 16'd10, 16'd0);
        send_request(ST_PENDING, 32'd201);
        send_request(ST_OPENED, 32'd202);
        send_request(ST_OPENED, 32'd202);
        drain_results();

        // floor above ceiling: the ceiling wins
        set_limits(16'd20, 16'd10, 16'd0, 16'd0);
        send_request(ST_PENDING, 32'd300);
        send_request(ST_OPENED, 32'd301);
        drain_results();

        // zero step: duty holds but the change time still moves
        set_limits(16'd0, 16'd100, 16'd0, 16'd5);
        send_request(ST_OPENED, 32'd400);
        drain_results();

        // widest step, full ceiling, longest delay: the sum saturates
        set_limits(16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        t = 32'd400;
        send_request(ST_OPENED, t + 32'd65534);
        send_request(ST_OPENED, t + 32'd65535);
        send_request(ST_OPENED, t + 32'd65535);
        send_request(ST_CLOSED, t + 32'd131070);
        send_request(ST_CLOSED, t + 32'd131070);
        drain_results();

        // --- random part: fresh limits each phase, extremes in the first two
        for (int p = 0; p < PHASES; p++)
        begin
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 4 == 2);
            if (p == 0)
                set_limits(16'd0, 16'h7FFF, 16'h7FFF, 16'd0);
            else if (p == 1)
                set_limits(16'h7FFF, 16'd0, 16'd1, 16'hFFFF);
            else
                random_limits();
            run_phase(PHASE_ITEMS);
            drain_results();
        end

        if (board.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vprc_pkg.sv
rtl/vprc_if.sv
rtl/valve_pwm_ramp_controller.sv
verif/valve_pwm_ramp_controller_test.sv
